FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; log_record_framer.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/lrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

    // Record length and brace depth counter width
    localparam int LENGTH_BITS = 16;
    localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [1:0] REG_FORMAT_MODE  = 2'd0;
    localparam logic [1:0] REG_STRICT_MODE  = 2'd1;
    localparam logic [1:0] REG_BUFFER_LIMIT = 2'd2;
    localparam logic [1:0] REG_SEND_LIMIT   = 2'd3;

    // Format modes
    localparam logic [1:0] FMT_PLAIN  = 2'd0;
    localparam logic [1:0] FMT_FILTER = 2'd1;
    localparam logic [1:0] FMT_JSON   = 2'd2;

    // Request kinds
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOI  = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_REC  = 2'd1,
        PH_HALT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_BYTE  = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_EOI_DROP  = 3'd3,
        ST_HALT      = 3'd4
    } status_t;

    typedef struct packed {
        status_t    status;
        logic       last;
        logic       valid;
        logic [7:0] out_byte;
    } result_t;

    // Saturating increment
    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] x);
        sat_inc = (x == CNT_MAX) ? x : x + LENGTH_BITS'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/log_record_framer.sv
// A result appears on the master side in the cycle after its input transfer
// when the output register is free or being read in that cycle.
// Throughput: one byte per cycle; a skid entry behind the output register takes one
// more transfer while a result waits for m_tready, then s_tready drops until it drains.
// Reset (rst_n, async, active low): hunting for a record, counters zero,
// output stage empty, registers at format 0, strict 0, both limits 65535.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module log_record_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] req_type
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,   // record_last
    output logic [3:0]       m_tuser    // [0] byte_valid, [3:1] status
);
    import lrf_pkg::*;

    logic [1:0]             format_mode_reg;
    logic                   strict_mode_reg;
    logic [15:0]            buffer_limit_reg;
    logic [15:0]            send_limit_reg;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] depth_reg, depth_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;

    logic                   out_valid_reg, skid_valid_reg;
    result_t                out_reg, skid_reg;

    logic                   accept, push;
    result_t                res;
    logic [7:0]             b;
    logic                   idx_valid, full, allowed, plain_last, json_over;
    logic [LENGTH_BITS-1:0] len_bump, depth_upd;
    logic [15:0]            split;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg  <= FMT_PLAIN;
            strict_mode_reg  <= 1'b0;
            buffer_limit_reg <= 16'hFFFF;
            send_limit_reg   <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT_MODE:  format_mode_reg  <= cfg_wdata[1:0];
                REG_STRICT_MODE:  strict_mode_reg  <= cfg_wdata[0];
                REG_BUFFER_LIMIT: buffer_limit_reg <= cfg_wdata;
                REG_SEND_LIMIT:   send_limit_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Shared per-byte decisions
    assign idx_valid  = length_reg < send_limit_reg;
    assign len_bump   = sat_inc(length_reg);
    assign full       = length_reg >= buffer_limit_reg;
    assign json_over  = len_bump >= buffer_limit_reg;
    assign split      = (buffer_limit_reg > 16'd1) ? buffer_limit_reg - 16'd1 : 16'd1;
    assign plain_last = (b == CH_NL) || (len_bump >= split);
    assign depth_upd  = (b == CH_LBRACE) ? sat_inc(depth_reg) :
                        ((b == CH_RBRACE) && (depth_reg != '0)) ?
                        depth_reg - LENGTH_BITS'(1) : depth_reg;

    always_comb
    begin
        allowed = (b inside {[CH_SPACE:CH_DEL], CH_TAB});
    end

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        depth_next  = depth_reg;
        length_next = length_reg;
        if (accept)
        begin
            if (s_tuser == REQ_EOI)
            begin
                phase_next  = PH_HUNT;
                depth_next  = '0;
                length_next = '0;
            end
            else if (phase_reg != PH_HALT)
            begin
                case (format_mode_reg)
                    FMT_PLAIN:
                    begin
                        if (plain_last)
                        begin
                            phase_next  = PH_HUNT;
                            depth_next  = '0;
                            length_next = '0;
                        end
                        else
                        begin
                            phase_next  = PH_REC;
                            length_next = len_bump;
                        end
                    end
                    FMT_FILTER:
                    begin
                        if (full || (!allowed && b != CH_NL && strict_mode_reg))
                        begin
                            phase_next  = PH_HALT;
                            depth_next  = '0;
                            length_next = '0;
                        end
                        else if (b == CH_NL)
                        begin
                            phase_next  = PH_HUNT;
                            depth_next  = '0;
                            length_next = '0;
                        end
                        else if (allowed)
                        begin
                            phase_next  = PH_REC;
                            length_next = len_bump;
                        end
                    end
                    FMT_JSON:
                    begin
                        if (phase_reg == PH_HUNT)
                        begin
                            if (b == CH_LBRACE)
                            begin
                                phase_next  = PH_REC;
                                depth_next  = LENGTH_BITS'(1);
                                length_next = LENGTH_BITS'(1);
                            end
                        end
                        else if (json_over)
                        begin
                            phase_next  = PH_HALT;
                            depth_next  = '0;
                            length_next = '0;
                        end
                        else if (depth_upd == '0)
                        begin
                            phase_next  = PH_HUNT;
                            depth_next  = '0;
                            length_next = '0;
                        end
                        else
                        begin
                            depth_next  = depth_upd;
                            length_next = len_bump;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Result for the byte being transferred
    always_comb
    begin
        push         = 1'b0;
        res.out_byte = b;
        res.valid    = idx_valid;
        res.last     = 1'b0;
        res.status   = ST_OK;
        if (s_tuser == REQ_EOI)
        begin
            res.out_byte = 8'h00;
            res.valid    = 1'b0;
            push         = accept && (phase_reg == PH_REC);
            if (format_mode_reg == FMT_PLAIN)
                res.last = 1'b1;
            else
                res.status = ST_EOI_DROP;
        end
        else if (phase_reg != PH_HALT)
        begin
            case (format_mode_reg)
                FMT_PLAIN:
                begin
                    push     = accept;
                    res.last = plain_last;
                end
                FMT_FILTER:
                begin
                    push = accept;
                    if (full)
                    begin
                        res.valid  = 1'b0;
                        res.status = ST_OVERFLOW;
                    end
                    else if (b == CH_NL)
                        res.last = 1'b1;
                    else if (!allowed)
                    begin
                        res.valid  = 1'b0;
                        res.status = strict_mode_reg ? ST_HALT : ST_BAD_BYTE;
                    end
                end
                FMT_JSON:
                begin
                    if (phase_reg == PH_HUNT)
                        push = accept && (b == CH_LBRACE);
                    else
                    begin
                        push = accept;
                        if (json_over)
                        begin
                            res.valid  = 1'b0;
                            res.status = ST_OVERFLOW;
                        end
                        else
                            res.last = (depth_upd == '0);
                    end
                end
                default: ;
            endcase
        end
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            depth_reg  <= '0;
            length_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            depth_reg  <= depth_next;
            length_reg <= length_next;
        end
    end

    // Output register and skid entry: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Output register and skid entry: payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (push)
            skid_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.status, out_reg.valid};

    // Checks
    `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPL(a_halt_silent, clk, rst_n,
        accept && (s_tuser == REQ_DATA) && (phase_reg == PH_HALT), !push)
    `ASSERT_NEXT(a_eoi_clears, clk, rst_n, accept && (s_tuser == REQ_EOI),
        (phase_reg == PH_HUNT) && (length_reg == '0) && (depth_reg == '0))
    `ASSERT_IMPL(a_depth_in_record, clk, rst_n, depth_reg != '0, phase_reg == PH_REC)

endmodule

`default_nettype wire
